// ===== hdl/knsq_pkg.sv =====
// knsq_pkg: shared widths, codes and structs of the k-nearest sorted queue
// no dependencies, imported by every module of the block
package knsq_pkg;

  localparam int MAX_K    = 16;
  localparam int CNT_W    = $clog2(MAX_K + 1);
  localparam int FUNC_W   = 2;
  localparam int ID_W     = 32;
  localparam int DIST_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int K_W      = 5;
  localparam int FILL_W   = 5;
  localparam int FIFO_AW  = 1;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [DIST_W-1:0] DIST_INF = '1;
  localparam logic [ID_W-1:0]   ID_EMPTY = '1;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

  // decoded operation, at most one bit set; none set is a no-op
  typedef struct packed {
    logic ins;
    logic clr;
    logic rd;
  } knsq_op_t;

  typedef struct packed {
    knsq_op_t              op;
    logic [ID_W-1:0]       cand_index;
    logic [DIST_W-1:0]     cand_distance;
    logic [SLOT_W-1:0]     slot;
  } knsq_item_t;

  typedef struct packed {
    logic                  rejected;
    logic [ID_W-1:0]       slot_index;
    logic [DIST_W-1:0]     slot_distance;
    logic [FILL_W-1:0]     fill_count;
    logic [DIST_W-1:0]     worst_distance;
  } knsq_result_t;

endpackage

// ===== hdl/k_nearest_sorted_queue_unit.sv =====
// k_nearest_sorted_queue_unit: top level of the k-nearest sorted queue
// depends on knsq_pkg, knsq_front, knsq_fifo and knsq_back
//
// usage: keeps the active_k candidates of smallest Q16.16 distance in
// ascending order. each input word carries a function (insert, clear, read
// slot, no-op) and gives exactly one result word with the rejected flag,
// the read slot contents, the fill count and the worst kept distance.
// channels: in_* and out_* are valid/ready, cfg_* is a valid/ready write
// of active_k (always ready); a write also empties the list and must only
// happen while no word is in flight.
// pipeline: an accepted word passes the input register and a queue entry,
// then the cell row loads the result register and out_valid rises;
// throughput is one word per cycle while out_ready is held high, set by
// the cell row, which compares all cells against the candidate and
// shifts them in the same cycle.
// reset: list empty, active_k 16, ready the cycle after reset drops; no
// clearing pass is needed since every cell resets to the empty value.
// stall: a held out_ready keeps the result word; the queue and input
// register take up to three more words before in_ready falls.
module k_nearest_sorted_queue_unit import knsq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [K_W-1:0]      cfg_active_k,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ID_W-1:0]     in_cand_index,
  input  logic [DIST_W-1:0]   in_cand_distance,
  input  logic [SLOT_W-1:0]   in_slot,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_rejected,
  output logic [ID_W-1:0]     out_slot_index,
  output logic [DIST_W-1:0]   out_slot_distance,
  output logic [FILL_W-1:0]   out_fill_count,
  output logic [DIST_W-1:0]   out_worst_distance
);

  // front to queue
  logic         f_valid, f_ready;
  knsq_item_t   f_item;
  // queue to back
  logic         b_valid, b_ready;
  knsq_item_t   b_item;
  knsq_result_t res;

  knsq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_cand_index    (in_cand_index),
    .in_cand_distance (in_cand_distance),
    .in_slot          (in_slot),
    .q_valid          (f_valid),
    .q_ready          (f_ready),
    .q_item           (f_item)
  );

  knsq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  knsq_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_active_k (cfg_active_k),
    .q_valid      (b_valid),
    .q_ready      (b_ready),
    .q_item       (b_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (res)
  );

  // split the result word onto its ports
  assign out_rejected       = res.rejected;
  assign out_slot_index     = res.slot_index;
  assign out_slot_distance  = res.slot_distance;
  assign out_fill_count     = res.fill_count;
  assign out_worst_distance = res.worst_distance;

endmodule

// ===== hdl/knsq_front.sv =====
// knsq_front: input register that accepts words and decodes the function code
// depends on knsq_pkg
module knsq_front import knsq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ID_W-1:0]     in_cand_index,
  input  logic [DIST_W-1:0]   in_cand_distance,
  input  logic [SLOT_W-1:0]   in_slot,
  output logic                q_valid,
  input  logic                q_ready,
  output knsq_item_t          q_item
);

  logic       vld_r, vld_nxt;
  knsq_item_t item_r, item_nxt;
  knsq_op_t   op_dec;

  always_comb begin
    op_dec = '0;
    case (in_func)
      FUNC_INSERT: op_dec.ins = 1'b1;
      FUNC_CLEAR:  op_dec.clr = 1'b1;
      FUNC_READ:   op_dec.rd  = 1'b1;
      FUNC_NOP:    op_dec     = '0;
      default:     op_dec     = '0;
    endcase
  end

  assign in_ready = !vld_r || q_ready;
  assign q_valid  = vld_r;
  assign q_item   = item_r;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (in_ready) begin
      vld_nxt = in_valid;
      if (in_valid) begin
        item_nxt.op            = op_dec;
        item_nxt.cand_index    = in_cand_index;
        item_nxt.cand_distance = in_cand_distance;
        item_nxt.slot          = in_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== hdl/knsq_fifo.sv =====
// knsq_fifo: short queue of decoded words between the front and the back
// depends on knsq_pkg
module knsq_fifo import knsq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  knsq_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output knsq_item_t pop_item
);

  localparam int CW = FIFO_AW + 1;

  knsq_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                push, pop;

  assign push_ready = count_r != CW'(FIFO_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/knsq_back.sv =====
// knsq_back: row of sorted cells that carries out insert, clear and read,
// plus the capacity register and the result register; depends on knsq_pkg
module knsq_back import knsq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [K_W-1:0]    cfg_active_k,
  input  logic              q_valid,
  output logic              q_ready,
  input  knsq_item_t        q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output knsq_result_t      out_res
);

  logic [ID_W-1:0]   id_r   [MAX_K];
  logic [ID_W-1:0]   id_nxt [MAX_K];
  logic [DIST_W-1:0] dist_r   [MAX_K];
  logic [DIST_W-1:0] dist_nxt [MAX_K];
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [DIST_W-1:0] worst_r, worst_nxt;
  logic              vld_r, vld_nxt;
  knsq_result_t      res_r, res_nxt;

  logic [MAX_K-1:0]  in_cap, is_last, lt, sel_new;
  logic              take, cfg_we, rej, prev_lt;
  logic [ID_W-1:0]   prev_id;
  logic [DIST_W-1:0] prev_dist;
  logic [CNT_W-1:0]  cap_cfg;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign q_ready   = !vld_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;
  assign rej       = q_item.cand_distance >= worst_r;

  // capacity clamp for a register write
  always_comb begin
    if (cfg_active_k == '0) begin
      cap_cfg = CNT_W'(1);
    end else if (32'(cfg_active_k) > MAX_K) begin
      cap_cfg = CNT_W'(MAX_K);
    end else begin
      cap_cfg = CNT_W'(cfg_active_k);
    end
  end

  // per-cell compare, first greater cell takes the candidate
  always_comb begin
    prev_lt = 1'b0;
    for (int i = 0; i < MAX_K; i++) begin
      in_cap[i]  = 32'(i) < 32'(cap_r);
      is_last[i] = 32'(i) == 32'(cap_r) - 32'd1;
      lt[i]      = q_item.cand_distance < dist_r[i];
      sel_new[i] = lt[i] && !prev_lt;
      prev_lt    = lt[i];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      id_nxt[i]   = id_r[i];
      dist_nxt[i] = dist_r[i];
    end
    occ_nxt   = occ_r;
    cap_nxt   = cap_r;
    prev_id   = ID_EMPTY;
    prev_dist = DIST_INF;
    if (cfg_we) begin
      cap_nxt = cap_cfg;
      occ_nxt = '0;
      for (int i = 0; i < MAX_K; i++) begin
        id_nxt[i]   = ID_EMPTY;
        dist_nxt[i] = DIST_INF;
      end
    end else if (take && q_item.op.clr) begin
      occ_nxt = '0;
      for (int i = 0; i < MAX_K; i++) begin
        id_nxt[i]   = ID_EMPTY;
        dist_nxt[i] = DIST_INF;
      end
    end else if (take && q_item.op.ins && !rej) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (in_cap[i] && lt[i]) begin
          if (sel_new[i]) begin
            id_nxt[i]   = q_item.cand_index;
            dist_nxt[i] = q_item.cand_distance;
          end else begin
            id_nxt[i]   = prev_id;
            dist_nxt[i] = prev_dist;
          end
        end
        prev_id   = id_r[i];
        prev_dist = dist_r[i];
      end
      if (occ_r < cap_r) begin
        occ_nxt = occ_r + 1'b1;
      end
    end
  end

  // bound of the last active cell after this cycle
  always_comb begin
    worst_nxt = '0;
    for (int i = 0; i < MAX_K; i++) begin
      worst_nxt = worst_nxt | (dist_nxt[i] & {DIST_W{is_last[i]}});
    end
    if (cfg_we) begin
      worst_nxt = DIST_INF;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (q_ready) begin
      vld_nxt = q_valid;
    end
    if (take) begin
      res_nxt.rejected       = q_item.op.ins && rej;
      res_nxt.slot_index     = '0;
      res_nxt.slot_distance  = '0;
      if (q_item.op.rd) begin
        res_nxt.slot_index    = ID_EMPTY;
        res_nxt.slot_distance = DIST_INF;
        for (int i = 0; i < MAX_K; i++) begin
          if (32'(q_item.slot) == 32'(i)) begin
            res_nxt.slot_index    = id_r[i];
            res_nxt.slot_distance = dist_r[i];
          end
        end
      end
      res_nxt.fill_count     = FILL_W'(occ_nxt);
      res_nxt.worst_distance = worst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_K; i++) begin
        id_r[i]   <= ID_EMPTY;
        dist_r[i] <= DIST_INF;
      end
      occ_r   <= '0;
      cap_r   <= CNT_W'(MAX_K);
      worst_r <= DIST_INF;
      vld_r   <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_K; i++) begin
        id_r[i]   <= id_nxt[i];
        dist_r[i] <= dist_nxt[i];
      end
      occ_r   <= occ_nxt;
      cap_r   <= cap_nxt;
      worst_r <= worst_nxt;
      vld_r   <= vld_nxt;
    end
    res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_occ_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cap_r)
    else $error("fill count above capacity");

  a_worst_inf_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r < cap_r) |-> (worst_r == DIST_INF))
    else $error("finite bound while list not full");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_we && take && q_item.op.clr) |=> (occ_r == '0 && worst_r == DIST_INF))
    else $error("clear left entries");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_we && take && q_item.op.ins && !rej && occ_r < cap_r)
      |=> (occ_r == $past(occ_r) + 1'b1))
    else $error("accepted insert did not grow the list");
`endif

endmodule
